/* rtl/xet_pkg.sv */
package xet_pkg;

  // limits of the open-element name stack
  localparam int MaxDepth  = 16;
  localparam int MaxName   = 32;
  localparam int StoreSize = MaxDepth * MaxName;

  localparam int DepthW = 5;                      // open_count field width
  localparam int IdxW   = $clog2(MaxName + 2);    // name index, saturates at MaxName + 1
  localparam int RowW   = $clog2(MaxDepth);
  localparam int ColW   = $clog2(MaxName);
  localparam int AddrW  = RowW + ColW;

  localparam int MaxEvents = 3;                   // events per input byte at most

  // event codes
  localparam logic [3:0] EvTextChar    = 4'd0;
  localparam logic [3:0] EvTextEnd     = 4'd1;
  localparam logic [3:0] EvTagChar     = 4'd2;
  localparam logic [3:0] EvTagEnd      = 4'd3;
  localparam logic [3:0] EvAttrChar    = 4'd4;
  localparam logic [3:0] EvAttrEnd     = 4'd5;
  localparam logic [3:0] EvValueChar   = 4'd6;
  localparam logic [3:0] EvValueEnd    = 4'd7;
  localparam logic [3:0] EvOpen        = 4'd8;
  localparam logic [3:0] EvDone        = 4'd9;
  localparam logic [3:0] EvCommentChar = 4'd10;
  localparam logic [3:0] EvCommentEnd  = 4'd11;
  localparam logic [3:0] EvError       = 4'd12;
  localparam logic [3:0] EvAccepted    = 4'd13;

  typedef struct packed {
    logic [3:0]        kind;
    logic [7:0]        data;
    logic [DepthW-1:0] count;
  } event_t;

  // all events caused by one input byte
  typedef struct packed {
    logic [1:0]                 num;
    event_t [MaxEvents-1:0]     ev;
  } bundle_t;

endpackage

/* rtl/xet_ram.sv */
module xet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/xet_front.sv */
module xet_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  input  logic              end_mark_i,
  input  logic              full_i,
  output logic              push_o,
  output xet_pkg::bundle_t  bundle_o
);

  localparam logic [3:0] PhBegin    = 4'd0;
  localparam logic [3:0] PhNode     = 4'd1;
  localparam logic [3:0] PhBody     = 4'd2;
  localparam logic [3:0] PhEquals   = 4'd3;
  localparam logic [3:0] PhValStart = 4'd4;
  localparam logic [3:0] PhClose    = 4'd5;
  localparam logic [3:0] PhText     = 4'd6;
  localparam logic [3:0] PhTagName  = 4'd7;
  localparam logic [3:0] PhAttrName = 4'd8;
  localparam logic [3:0] PhValue    = 4'd9;
  localparam logic [3:0] PhWaitEnd  = 4'd10;
  localparam logic [3:0] PhComment  = 4'd11;
  localparam logic [3:0] PhSkip     = 4'd12;
  localparam logic [3:0] PhStart    = 4'd13;
  localparam logic [3:0] PhDone     = 4'd14;
  localparam logic [3:0] PhFailed   = 4'd15;

  localparam int Passes = 8;

  typedef struct packed {
    logic [3:0]                 phase;
    logic [3:0]                 resume;
    logic                       quote;
    logic [1:0]                 mark;
    logic [xet_pkg::DepthW-1:0] depth;
    logic [xet_pkg::IdxW-1:0]   idx;
    logic                       mismatch;
    logic                       root_done;
    logic                       err;
  } state_t;

  function automatic logic name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h3a || c == 8'h2e ||
           c == 8'h5f || c == 8'h2d;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  state_t state_q, state_d, state_c;
  logic [xet_pkg::IdxW-1:0] lens_q [xet_pkg::MaxDepth];

  logic                       accept;
  logic                       st_we_c, len_we_c;
  logic [xet_pkg::AddrW-1:0]  st_waddr_c, st_raddr;
  logic [7:0]                 st_wdata_c, st_rdata;
  logic [xet_pkg::RowW-1:0]   len_waddr_c;
  logic [xet_pkg::IdxW-1:0]   len_wdata_c;
  xet_pkg::bundle_t           bundle_c;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin : parse
    state_t                   s;
    logic                     go, f, e_v;
    logic [3:0]               e_kind;
    logic [7:0]               e_data;
    logic [1:0]               n;
    logic [xet_pkg::RowW-1:0] top;
    logic [xet_pkg::IdxW-1:0] len;
    logic [7:0]               c;
    s           = state_q;
    c           = ch_i;
    n           = 2'd0;
    bundle_c    = '0;
    st_we_c     = 1'b0;
    st_waddr_c  = '0;
    st_wdata_c  = c;
    len_we_c    = 1'b0;
    len_waddr_c = '0;
    len_wdata_c = '0;
    go          = 1'b0;
    f           = 1'b0;
    e_v         = 1'b0;
    e_kind      = xet_pkg::EvError;
    e_data      = 8'd0;
    top         = '0;
    len         = '0;
    if (end_mark_i) begin
      e_kind = (s.root_done && !s.err) ? xet_pkg::EvAccepted : xet_pkg::EvError;
      s = '0;
      s.phase  = PhStart;
      s.resume = PhBegin;
      bundle_c.ev[0].kind  = e_kind;
      bundle_c.ev[0].data  = 8'd0;
      bundle_c.ev[0].count = '0;
      n = 2'd1;
    end else if (s.phase == PhDone || s.phase == PhFailed) begin
      // ignored until end mark
    end else if (c == 8'd0) begin
      s.err   = 1'b1;
      s.phase = PhFailed;
      bundle_c.ev[0].kind  = xet_pkg::EvError;
      bundle_c.ev[0].data  = 8'd0;
      bundle_c.ev[0].count = s.depth;
      n = 2'd1;
    end else begin
      go = 1'b1;
    end

    for (int i = 0; i < Passes; i++) begin
      if (go) begin
        go     = 1'b0;
        f      = 1'b0;
        e_v    = 1'b0;
        e_kind = xet_pkg::EvError;
        e_data = 8'd0;
        top    = xet_pkg::RowW'(s.depth - 1'b1);
        len    = lens_q[top];
        unique case (s.phase)
          PhStart: begin
            if (s.mark == 2'd0 && c == 8'hef) begin
              s.mark = 2'd1;
            end else if (s.mark == 2'd1) begin
              if (c == 8'hbb) s.mark = 2'd2;
              else f = 1'b1;
            end else if (s.mark == 2'd2) begin
              if (c == 8'hbf) begin
                s.mark = 2'd3; s.phase = PhSkip; s.resume = PhBegin;
              end else begin
                f = 1'b1;
              end
            end else begin
              s.phase = PhSkip; s.resume = PhBegin; go = 1'b1;
            end
          end
          PhSkip: begin
            if (!is_space(c)) begin
              s.phase = s.resume; go = 1'b1;
            end
          end
          PhBegin: begin
            if (c == 8'h3c) begin
              s.phase = PhSkip; s.resume = PhNode;
            end else if (s.depth == '0) begin
              f = 1'b1;
            end else begin
              e_v = 1'b1; e_kind = xet_pkg::EvTextChar; e_data = c; s.phase = PhText;
            end
          end
          PhText: begin
            if (c == 8'h3c) begin
              e_v = 1'b1; e_kind = xet_pkg::EvTextEnd;
              s.phase = PhSkip; s.resume = PhNode;
            end else begin
              e_v = 1'b1; e_kind = xet_pkg::EvTextChar; e_data = c;
            end
          end
          PhNode: begin
            if (c == 8'h21) begin
              s.phase = PhComment;
            end else if (c == 8'h2f) begin
              if (s.depth == '0) f = 1'b1;
              else begin
                s.idx = '0; s.mismatch = 1'b0; s.phase = PhSkip; s.resume = PhClose;
              end
            end else if (s.depth >= xet_pkg::DepthW'(xet_pkg::MaxDepth)) begin
              f = 1'b1;
            end else begin
              s.idx = '0; s.phase = PhTagName; go = 1'b1;
            end
          end
          PhTagName: begin
            if (name_char(c)) begin
              if (s.idx >= xet_pkg::IdxW'(xet_pkg::MaxName)) begin
                f = 1'b1;
              end else begin
                st_we_c    = 1'b1;
                st_waddr_c = {s.depth[xet_pkg::RowW-1:0], s.idx[xet_pkg::ColW-1:0]};
                s.idx      = s.idx + 1'b1;
                e_v = 1'b1; e_kind = xet_pkg::EvTagChar; e_data = c;
              end
            end else if (s.idx == '0 ||
                         s.depth >= xet_pkg::DepthW'(xet_pkg::MaxDepth)) begin
              f = 1'b1;
            end else begin
              len_we_c    = 1'b1;
              len_waddr_c = s.depth[xet_pkg::RowW-1:0];
              len_wdata_c = s.idx;
              e_v = 1'b1; e_kind = xet_pkg::EvTagEnd;
              s.phase = PhSkip; s.resume = PhBody; go = 1'b1;
            end
          end
          PhBody: begin
            if (c == 8'h2f) begin
              s.depth = s.depth + 1'b1; e_v = 1'b1; e_kind = xet_pkg::EvOpen;
              s.phase = PhWaitEnd;
            end else if (c == 8'h3e) begin
              s.depth = s.depth + 1'b1; e_v = 1'b1; e_kind = xet_pkg::EvOpen;
              s.phase = PhSkip; s.resume = PhBegin;
            end else begin
              s.idx = '0; s.phase = PhAttrName; go = 1'b1;
            end
          end
          PhAttrName: begin
            if (name_char(c)) begin
              s.idx = xet_pkg::IdxW'(1);
              e_v = 1'b1; e_kind = xet_pkg::EvAttrChar; e_data = c;
            end else if (s.idx == '0) begin
              f = 1'b1;
            end else begin
              e_v = 1'b1; e_kind = xet_pkg::EvAttrEnd;
              s.phase = PhSkip; s.resume = PhEquals; go = 1'b1;
            end
          end
          PhEquals: begin
            if (c == 8'h3d) begin
              s.phase = PhSkip; s.resume = PhValStart;
            end else begin
              f = 1'b1;
            end
          end
          PhValStart: begin
            if (c == 8'h22) begin
              s.quote = 1'b0; s.phase = PhValue;
            end else if (c == 8'h27) begin
              s.quote = 1'b1; s.phase = PhValue;
            end else begin
              f = 1'b1;
            end
          end
          PhValue: begin
            if (c == (s.quote ? 8'h27 : 8'h22)) begin
              e_v = 1'b1; e_kind = xet_pkg::EvValueEnd;
              s.phase = PhSkip; s.resume = PhBody;
            end else begin
              e_v = 1'b1; e_kind = xet_pkg::EvValueChar; e_data = c;
            end
          end
          PhWaitEnd, PhClose: begin
            if (s.phase == PhClose && s.depth == '0) begin
              f = 1'b1;
            end else if (s.phase == PhClose && name_char(c)) begin
              // stored byte for this row and index was fetched in the previous cycle
              if (!(s.idx < len && s.idx < xet_pkg::IdxW'(xet_pkg::MaxName) &&
                    fold(c) == fold(st_rdata))) begin
                s.mismatch = 1'b1;
              end
              if (s.idx <= xet_pkg::IdxW'(xet_pkg::MaxName)) s.idx = s.idx + 1'b1;
            end else if (c != 8'h3e || (s.phase == PhClose &&
                         (s.idx == '0 || s.mismatch || s.idx != len))) begin
              f = 1'b1;
            end else begin
              // element finished
              if (s.depth != '0) s.depth = s.depth - 1'b1;
              e_v = 1'b1; e_kind = xet_pkg::EvDone;
              if (s.depth == '0) begin
                s.root_done = 1'b1; s.phase = PhDone;
              end else begin
                s.phase = PhSkip; s.resume = PhBegin;
              end
            end
          end
          PhComment: begin
            if (c == 8'h3e) begin
              e_v = 1'b1; e_kind = xet_pkg::EvCommentEnd;
              s.phase = PhSkip; s.resume = PhBegin;
            end else begin
              e_v = 1'b1; e_kind = xet_pkg::EvCommentChar; e_data = c;
            end
          end
          default: begin
          end
        endcase
        if (f) begin
          s.err = 1'b1; s.phase = PhFailed;
          e_v = 1'b1; e_kind = xet_pkg::EvError; e_data = 8'd0;
        end
        if (e_v && n < 2'd3) begin
          bundle_c.ev[n].kind  = e_kind;
          bundle_c.ev[n].data  = e_data;
          bundle_c.ev[n].count = s.depth;
          n = n + 2'd1;
        end
        if (s.phase == PhFailed) go = 1'b0;
      end
    end
    bundle_c.num = n;
    state_c      = s;
  end

  assign state_d  = accept ? state_c : state_q;
  assign st_raddr = {xet_pkg::RowW'(state_d.depth - 1'b1), state_d.idx[xet_pkg::ColW-1:0]};
  assign push_o   = accept && (bundle_c.num != 2'd0);
  assign bundle_o = bundle_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhStart, resume: PhBegin, default: '0};
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && len_we_c) begin
      lens_q[len_waddr_c] <= len_wdata_c;
    end
  end

  xet_ram #(
    .WIDTH(8),
    .DEPTH(xet_pkg::StoreSize)
  ) u_name_store (
    .clk_i  (clk_i),
    .we_i   (accept && st_we_c),
    .waddr_i(st_waddr_c),
    .wdata_i(st_wdata_c),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

endmodule

/* rtl/xet_back.sv */
module xet_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  xet_pkg::bundle_t           bundle_i,
  output logic                       full_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 event_res_o,
  output logic [7:0]                 data_byte_o,
  output logic [xet_pkg::DepthW-1:0] open_count_o,
  output logic                       run_last_o
);

  xet_pkg::bundle_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q, sub_q;
  xet_pkg::bundle_t head;
  logic             last, pop;

  assign head         = mem_q[rd_q];
  assign full_o       = cnt_q == 2'd2;
  assign out_valid_o  = cnt_q != 2'd0;
  assign last         = sub_q == head.num - 2'd1;
  assign pop          = out_valid_o && out_ready_i && last;
  assign event_res_o  = head.ev[sub_q].kind;
  assign data_byte_o  = head.ev[sub_q].data;
  assign open_count_o = head.ev[sub_q].count;
  assign run_last_o   = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
      sub_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
      if (out_valid_o && out_ready_i) sub_q <= last ? 2'd0 : sub_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

endmodule

/* rtl/xml_event_tokenizer_core.sv */
// channel | signals                                  | transfer when
// input   | ch_i, end_mark_i                         | in_valid_i && in_ready_o
// output  | event_res_o, data_byte_o, open_count_o,  | out_valid_o && out_ready_i
//         | run_last_o                               |
//
// one byte is taken per cycle; its up to three events go into a two-entry
// queue and leave one per cycle, so each event of a byte is its own output transfer
// the name compare on close tags uses a registered read of the name ram
// rst_ni clears the parser to document start; the name ram is not cleared
// input stalls only while the queue is full, output stalls hold the head event
module xml_event_tokenizer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 ch_i,
  input  logic                       end_mark_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 event_res_o,
  output logic [7:0]                 data_byte_o,
  output logic [xet_pkg::DepthW-1:0] open_count_o,
  output logic                       run_last_o
);

  logic             push, full;
  xet_pkg::bundle_t bundle;

  // front: classify bytes and build the event bundle
  xet_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .ch_i      (ch_i),
    .end_mark_i(end_mark_i),
    .full_i    (full),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  // back: queue bundles and hand out events one transfer at a time
  xet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .bundle_i    (bundle),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_res_o (event_res_o),
    .data_byte_o (data_byte_o),
    .open_count_o(open_count_o),
    .run_last_o  (run_last_o)
  );

endmodule
